// ===== hdl/rotary_encoder_mode_values_macros.svh =====
// ----------------------------------------------------------------------------
// Rotary encoder mode values: assertion macros
// Shared concurrent check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_MODE_VALUES_MACROS_SVH
`define ROTARY_ENCODER_MODE_VALUES_MACROS_SVH

// same-cycle implication
`define REMV_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("remv: same-cycle check failed");

// next-cycle implication
`define REMV_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("remv: next-cycle check failed");

`endif

// ===== hdl/remv_pkg.sv =====
// ----------------------------------------------------------------------------
// remv_pkg
// Widths, register indexes, codes and the quadrature decode table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package remv_pkg;

  localparam int TIME_BITS      = 32;
  localparam int LIM_BITS       = 16;
  localparam int IDLE_TO_BITS   = 16;
  localparam int MODE_TO_BITS   = 32;
  localparam int NUM_MODES      = 4;
  localparam int MODE_BITS      = 2;
  localparam int EV_BITS        = 2;
  localparam int OUT_VAL_BITS   = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam int VALUE_BITS_DEF     = 16;
  localparam int TRANS_PER_STEP_DEF = 4;

  localparam logic [LIM_BITS-1:0]     MAX_DEF      = 16'd255;
  localparam logic [NUM_MODES-1:0]    SAT_MASK_DEF = 4'h0;
  localparam logic [IDLE_TO_BITS-1:0] IDLE_TO_DEF  = 16'd100;
  localparam logic [MODE_TO_BITS-1:0] MODE_TO_DEF  = 32'd10000;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_NORMAL  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CLICKED = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DOUBLE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_HELD    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAT_MASK    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TO     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE_TO     = 3'd6;

  // modes
  localparam logic [MODE_BITS-1:0] MODE_NORMAL  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_CLICKED = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DOUBLE  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_HELD    = 2'd3;

  // button events
  localparam logic [EV_BITS-1:0] EV_NONE = 2'd0;

  // detent steps
  localparam logic signed [1:0] STEP_ZERO = 2'sb00;
  localparam logic signed [1:0] STEP_POS  = 2'sb01;
  localparam logic signed [1:0] STEP_NEG  = 2'sb11;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // index is {previous B, previous A, current B, current A}
  function automatic logic signed [1:0] quad_dir(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx) inside
      4'd2, 4'd4, 4'd11, 4'd13: d = STEP_POS;
      4'd1, 4'd7, 4'd8, 4'd14:  d = STEP_NEG;
      default:                  d = STEP_ZERO;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/remv_div.sv =====
// ----------------------------------------------------------------------------
// remv_div
// Bit-serial remainder unit: dividend mod (lim + 1), one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module remv_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [remv_pkg::LIM_BITS-1:0]  dividend,
  input  logic [remv_pkg::LIM_BITS-1:0]  lim,
  output remv_pkg::div_stat_t            stat,
  output logic [remv_pkg::LIM_BITS-1:0]  rem
);
  import remv_pkg::*;

  localparam int CNT_BITS = $clog2(LIM_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(LIM_BITS - 1);

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } div_state_t;

  div_state_t            st_r;
  logic                  done_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [LIM_BITS-1:0]   quo_r;
  logic [LIM_BITS:0]     rem_r;
  logic [LIM_BITS:0]     dsr_r;

  logic [LIM_BITS+1:0]   trial;
  logic [LIM_BITS+1:0]   diff;
  logic                  ge;
  logic [LIM_BITS:0]     rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[LIM_BITS-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[LIM_BITS:0] : trial[LIM_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DIV_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        st_r <= DIV_RUN;
      end else if (st_r == DIV_RUN && cnt_r == CNT_LAST) begin
        st_r   <= DIV_IDLE;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= {1'b0, lim} + (LIM_BITS+1)'(1);
      cnt_r <= '0;
    end else if (st_r == DIV_RUN) begin
      quo_r <= {quo_r[LIM_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_BITS'(1);
    end
  end

  assign stat.busy = (st_r == DIV_RUN) || done_r;
  assign stat.done = done_r;
  assign rem       = rem_r[LIM_BITS-1:0];

endmodule

// ===== hdl/rotary_encoder_mode_values.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_mode_values
// Quadrature encoder decoder with button-selected modes and one value per mode.
// Each item is one pin sample with a millisecond timestamp and a button event;
// each item yields exactly one result. Items are taken one per clock unless
// in_stall or out_stall holds them, and pass an input register, then a result
// register; the decode, the detent rounding, the mode timer and the value update
// all sit in one combinational pass between those registers. Writing one of the
// four limit registers starts a bit-serial remainder of that mode's value by the
// new limit plus one; in_stall stays high while that unit runs. Other configuration
// writes take effect at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotary_encoder_mode_values_macros.svh"

module rotary_encoder_mode_values #(
  parameter int VALUE_BITS           = remv_pkg::VALUE_BITS_DEF,
  parameter int TRANSITIONS_PER_STEP = remv_pkg::TRANS_PER_STEP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [remv_pkg::TIME_BITS-1:0]      in_time_ms,
  input  logic                                in_quad_a,
  input  logic                                in_quad_b,
  input  logic [remv_pkg::EV_BITS-1:0]        in_button_event,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [remv_pkg::MODE_BITS-1:0]      out_mode,
  output logic                                out_mode_changed,
  output logic signed [1:0]                   out_step,
  output logic                                out_value_changed,
  output logic [remv_pkg::OUT_VAL_BITS-1:0]   out_mode_value,
  input  logic                                cfg_we,
  input  logic [remv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [remv_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import remv_pkg::*;

  localparam int SUM_BITS = $clog2(TRANSITIONS_PER_STEP + 1) + 1;
  localparam logic [SUM_BITS-1:0] T_U = SUM_BITS'(TRANSITIONS_PER_STEP);

  // configuration
  logic [LIM_BITS-1:0]     max_r [NUM_MODES];
  logic [NUM_MODES-1:0]    sat_r;
  logic [IDLE_TO_BITS-1:0] ito_r;
  logic [MODE_TO_BITS-1:0] mto_r;

  // item state
  logic [1:0]                 prev_ab_r;
  logic signed [SUM_BITS-1:0] sum_r;
  logic [TIME_BITS-1:0]       lmt_r;
  logic [MODE_BITS-1:0]       mode_r;
  logic [TIME_BITS-1:0]       mset_r;
  logic [VALUE_BITS-1:0]      val_r [NUM_MODES];
  logic [LIM_BITS-1:0]        red_r [NUM_MODES];

  // input register
  logic                  s1_vld_r;
  logic [TIME_BITS-1:0]  s1_time_r;
  logic [1:0]            s1_ab_r;
  logic [EV_BITS-1:0]    s1_ev_r;

  // result register
  logic                      out_valid_r;
  logic [MODE_BITS-1:0]      out_mode_r;
  logic                      out_mc_r;
  logic signed [1:0]         out_step_r;
  logic                      out_vc_r;
  logic [OUT_VAL_BITS-1:0]   out_val_r;

  // remainder units
  div_stat_t             div_stat [NUM_MODES];
  logic [LIM_BITS-1:0]   div_rem  [NUM_MODES];
  logic [NUM_MODES-1:0]  div_start;
  logic                  busy_any;

  // handshake
  logic in_acc;
  logic adv;
  logic fire;

  // datapath
  logic [MODE_BITS-1:0]       mode_a;
  logic [TIME_BITS-1:0]       mset_a;
  logic                       mto_hit;
  logic [MODE_BITS-1:0]       mode_nxt;
  logic [TIME_BITS-1:0]       mset_nxt;
  logic                       mc_c;
  logic signed [1:0]          tr;
  logic signed [SUM_BITS-1:0] sum_a;
  logic [TIME_BITS-1:0]       lmt_a;
  logic [SUM_BITS-1:0]        mag;
  logic                       trig;
  logic                       round_up;
  logic signed [1:0]          step_c;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic [TIME_BITS-1:0]       lmt_nxt;
  logic [LIM_BITS-1:0]        lim;
  logic [LIM_BITS-1:0]        cur16;
  logic [LIM_BITS-1:0]        red;
  logic [LIM_BITS-1:0]        new16;
  logic [VALUE_BITS-1:0]      new_v;
  logic                       upd;
  logic [OUT_VAL_BITS-1:0]    mval_c;
  logic [SUM_BITS-1:0]        sum_r_mag;

  // ---------------------------------------------------------------- handshake
  always_comb begin
    busy_any = 1'b0;
    for (int m = 0; m < NUM_MODES; m++) begin
      busy_any = busy_any | div_stat[m].busy;
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_vld_r && adv && !busy_any;
  assign in_stall = busy_any || (s1_vld_r && !fire);
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------- config
  always_comb begin
    div_start = '0;
    if (cfg_we) begin
      case (cfg_index) inside
        [CFG_MAX_NORMAL:CFG_MAX_HELD]: div_start[cfg_index[MODE_BITS-1:0]] = 1'b1;
        default:                       div_start = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MODES; m++) begin
        max_r[m] <= MAX_DEF;
      end
      sat_r <= SAT_MASK_DEF;
      ito_r <= IDLE_TO_DEF;
      mto_r <= MODE_TO_DEF;
    end else if (cfg_we) begin
      case (cfg_index) inside
        [CFG_MAX_NORMAL:CFG_MAX_HELD]:
          max_r[cfg_index[MODE_BITS-1:0]] <= cfg_wdata[LIM_BITS-1:0];
        CFG_SAT_MASK: sat_r <= cfg_wdata[NUM_MODES-1:0];
        CFG_IDLE_TO:  ito_r <= cfg_wdata[IDLE_TO_BITS-1:0];
        CFG_MODE_TO:  mto_r <= cfg_wdata[MODE_TO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    // button event, then mode timeout
    mode_a   = (s1_ev_r != EV_NONE) ? s1_ev_r : mode_r;
    mset_a   = (s1_ev_r != EV_NONE) ? s1_time_r : mset_r;
    mto_hit  = ((s1_time_r - mset_a) > mto_r) && (mode_a != MODE_NORMAL);
    mode_nxt = mto_hit ? MODE_NORMAL : mode_a;
    mset_nxt = mto_hit ? s1_time_r : mset_a;
    mc_c     = (s1_ev_r != EV_NONE) || mto_hit;

    // decode and accumulate
    tr    = quad_dir({prev_ab_r, s1_ab_r});
    sum_a = sum_r + SUM_BITS'(tr);
    lmt_a = (tr != STEP_ZERO) ? s1_time_r : lmt_r;
    mag   = sum_a[SUM_BITS-1] ? SUM_BITS'(-sum_a) : SUM_BITS'(sum_a);
    trig  = (mag >= T_U) ||
            (((s1_time_r - lmt_a) > TIME_BITS'(ito_r)) && (sum_a != '0));
    // |sum| never exceeds T here, so half-away rounding is 2|sum| >= T
    round_up = {mag, 1'b0} >= {1'b0, T_U};
    step_c   = STEP_ZERO;
    if (trig && round_up) begin
      step_c = sum_a[SUM_BITS-1] ? STEP_NEG : STEP_POS;
    end
    sum_nxt = trig ? '0 : sum_a;
    lmt_nxt = trig ? s1_time_r : lmt_a;

    // value update of the current mode
    lim   = max_r[mode_nxt];
    cur16 = LIM_BITS'(val_r[mode_nxt]);
    red   = red_r[mode_nxt];
    upd   = (step_c != STEP_ZERO);
    if (sat_r[mode_nxt]) begin
      if (step_c == STEP_POS) begin
        new16 = (cur16 >= lim) ? lim : cur16 + LIM_BITS'(1);
      end else if (cur16 == '0) begin
        new16 = '0;
      end else begin
        new16 = ((cur16 - LIM_BITS'(1)) > lim) ? lim : cur16 - LIM_BITS'(1);
      end
    end else begin
      // red holds the value already reduced mod (lim + 1)
      if (step_c == STEP_POS) begin
        new16 = (red == lim) ? '0 : red + LIM_BITS'(1);
      end else begin
        new16 = (red == '0) ? lim : red - LIM_BITS'(1);
      end
    end
    new_v  = VALUE_BITS'(new16);
    mval_c = upd ? OUT_VAL_BITS'(new_v) : OUT_VAL_BITS'(val_r[mode_nxt]);
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= '0;
      sum_r     <= '0;
      lmt_r     <= '0;
      mode_r    <= MODE_NORMAL;
      mset_r    <= '0;
    end else if (fire) begin
      prev_ab_r <= s1_ab_r;
      sum_r     <= sum_nxt;
      lmt_r     <= lmt_nxt;
      mode_r    <= mode_nxt;
      mset_r    <= mset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MODES; m++) begin
        val_r[m] <= '0;
        red_r[m] <= '0;
      end
    end else begin
      for (int m = 0; m < NUM_MODES; m++) begin
        if (div_stat[m].done) begin
          red_r[m] <= div_rem[m];
        end else if (fire && upd && mode_nxt == MODE_BITS'(m)) begin
          red_r[m] <= LIM_BITS'(new_v);
        end
        if (fire && upd && mode_nxt == MODE_BITS'(m)) begin
          val_r[m] <= new_v;
        end
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (fire) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_time_r <= in_time_ms;
      s1_ab_r   <= {in_quad_b, in_quad_a};
      s1_ev_r   <= in_button_event;
    end
    if (fire) begin
      out_mode_r <= mode_nxt;
      out_mc_r   <= mc_c;
      out_step_r <= step_c;
      out_vc_r   <= upd;
      out_val_r  <= mval_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = out_mode_r;
  assign out_mode_changed  = out_mc_r;
  assign out_step          = out_step_r;
  assign out_value_changed = out_vc_r;
  assign out_mode_value    = out_val_r;

  // ---------------------------------------------------------------- remainder
  // the divisor is taken from the write data, since max_r updates on the same edge
  for (genvar g = 0; g < NUM_MODES; g++) begin : g_div
    remv_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start[g]),
      .dividend (LIM_BITS'(val_r[g])),
      .lim      (cfg_wdata[LIM_BITS-1:0]),
      .stat     (div_stat[g]),
      .rem      (div_rem[g])
    );
  end

  // ---------------------------------------------------------------- checks
  assign sum_r_mag = sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);

  `REMV_ASSERT_NOW(a_sum_below_step, clk, rst_n, 1'b1, sum_r_mag < T_U)
  `REMV_ASSERT_NOW(a_busy_stalls, clk, rst_n, busy_any, in_stall)
  `REMV_ASSERT_NEXT(a_fire_to_out, clk, rst_n, fire, out_valid_r)
  `REMV_ASSERT_NOW(a_step_flag, clk, rst_n, out_valid_r, out_vc_r == (out_step_r != STEP_ZERO))

  for (genvar g = 0; g < NUM_MODES; g++) begin : g_chk
    `REMV_ASSERT_NOW(a_red_in_range, clk, rst_n, !div_stat[g].busy, red_r[g] <= max_r[g])
  end

endmodule

// ===== tb/sv/rotary_encoder_mode_values_tb.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_mode_values_tb
// Self-checking bench for the quadrature decoder with per-mode values. A
// driver feeds pin samples from a queue and a monitor predicts one readout
// for each accepted sample. Each readout is checked field by field, in order.
// The run sweeps several register settings, with random idling on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_mode_values_tb;
  import remv_pkg::*;

  localparam int STEPS          = TRANS_PER_STEP_DEF;
  localparam int HOLD_LEN       = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [EV_BITS-1:0]      EV_CLICK   = 2'd1;
  localparam logic [EV_BITS-1:0]      EV_DOUBLE  = 2'd2;
  localparam logic [EV_BITS-1:0]      EV_HOLD    = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_ms;
    logic [1:0]           ab;       // {B, A}
    logic [EV_BITS-1:0]   ev;
  } sample_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]    mode;
    logic                    mode_changed;
    logic signed [1:0]       step;
    logic                    value_changed;
    logic [OUT_VAL_BITS-1:0] mode_value;
  } readout_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [TIME_BITS-1:0]     in_time_ms = '0;
  logic                     in_quad_a = 1'b0;
  logic                     in_quad_b = 1'b0;
  logic [EV_BITS-1:0]       in_button_event = EV_NONE;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [MODE_BITS-1:0]     out_mode;
  logic                     out_mode_changed;
  logic signed [1:0]        out_step;
  logic                     out_value_changed;
  logic [OUT_VAL_BITS-1:0]  out_mode_value;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  rotary_encoder_mode_values dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_time_ms       (in_time_ms),
    .in_quad_a        (in_quad_a),
    .in_quad_b        (in_quad_b),
    .in_button_event  (in_button_event),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mode         (out_mode),
    .out_mode_changed (out_mode_changed),
    .out_step         (out_step),
    .out_value_changed(out_value_changed),
    .out_mode_value   (out_mode_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder state and register copy
  int                   turn_tbl [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  logic [1:0]           pv_ab = 2'b00;
  int                   pv_sum = 0;
  logic [TIME_BITS-1:0] pv_move_t = '0;
  logic [MODE_BITS-1:0] pv_mode = MODE_NORMAL;
  logic [TIME_BITS-1:0] pv_mode_t = '0;
  logic [15:0]          pv_val [NUM_MODES] = '{default: '0};
  logic [15:0]          pv_lim [NUM_MODES] = '{default: MAX_DEF};
  logic [3:0]           pv_sat = SAT_MASK_DEF;
  logic [15:0]          pv_idle_to = IDLE_TO_DEF;
  logic [31:0]          pv_mode_to = MODE_TO_DEF;

  sample_t  sample_q [$];
  readout_t readout_q [$];

  int  mismatches = 0;
  int  n_samples = 0;
  int  n_results = 0;
  int  n_steps = 0;
  int  n_mode_changes = 0;
  int  n_cfg_writes = 0;
  int  idle_cycles = 0;
  int  snd_gap = 0;
  int  rcv_gap = 0;
  int  hold_left = 0;
  int  hold_asks = 0;
  int  holds_served = 0;
  bit  calm = 1'b0;
  bit  in_acc = 1'b0;
  bit  out_acc = 1'b0;

  // stimulus generator state
  logic [TIME_BITS-1:0] clock_ms = '0;
  logic [1:0]           pin_now = 2'b00;
  bit                   turn_up = 1'b1;

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      CFG_MAX_NORMAL, CFG_MAX_CLICKED, CFG_MAX_DOUBLE, CFG_MAX_HELD: pv_lim[idx[1:0]] = d[15:0];
      CFG_SAT_MASK: pv_sat = d[3:0];
      CFG_IDLE_TO:  pv_idle_to = d[15:0];
      CFG_MODE_TO:  pv_mode_to = d[31:0];
      default: ;
    endcase
  endfunction

  function automatic readout_t decode_sample(input sample_t s);
    readout_t             r;
    int                   turn;
    int                   mag;
    int                   rnd;
    int                   st;
    logic [TIME_BITS-1:0] since;
    longint               v;
    longint               lim;
    logic [1:0]           m;
    r = '0;
    if (s.ev != EV_NONE) begin
      pv_mode = s.ev;
      pv_mode_t = s.time_ms;
      r.mode_changed = 1'b1;
    end
    since = s.time_ms - pv_mode_t;
    if (since > pv_mode_to && pv_mode != MODE_NORMAL) begin
      pv_mode = MODE_NORMAL;
      pv_mode_t = s.time_ms;
      r.mode_changed = 1'b1;
    end
    turn = turn_tbl[{pv_ab, s.ab}];
    pv_ab = s.ab;
    pv_sum += turn;
    if (turn != 0) pv_move_t = s.time_ms;
    mag = (pv_sum < 0) ? -pv_sum : pv_sum;
    since = s.time_ms - pv_move_t;
    st = 0;
    if (mag >= STEPS || (since > pv_idle_to && pv_sum != 0)) begin
      rnd = (2 * mag + STEPS) / (2 * STEPS);
      st = (pv_sum < 0) ? -rnd : rnd;
      pv_sum = 0;
      pv_move_t = s.time_ms;
    end
    m = pv_mode;
    if (st != 0) begin
      lim = pv_lim[m];
      v = longint'(pv_val[m]) + st;
      if (pv_sat[m]) begin
        if (v > lim) v = lim;
        if (v < 0) v = 0;
      end else begin
        v = v % (lim + 1);
        if (v < 0) v += lim + 1;
      end
      pv_val[m] = v[15:0];
      r.value_changed = 1'b1;
    end
    r.mode = pv_mode;
    r.step = (st == 0) ? STEP_ZERO : (st > 0) ? STEP_POS : STEP_NEG;
    r.mode_value = pv_val[pv_mode];
    return r;
  endfunction

  // monitor: register copy, sample capture, readout check, watchdog
  readout_t want;
  readout_t got;
  always @(posedge clk) begin
    in_acc = rst_n && in_valid && !in_stall;
    out_acc = rst_n && out_valid && !out_stall;
    if (rst_n && cfg_we) begin
      apply_reg(cfg_index, cfg_wdata);
      n_cfg_writes++;
    end
    if (in_acc) begin
      want = decode_sample('{in_time_ms, {in_quad_b, in_quad_a}, in_button_event});
      readout_q.push_back(want);
      n_samples++;
      if (want.step != STEP_ZERO) n_steps++;
      if (want.mode_changed) n_mode_changes++;
    end
    if (out_acc) begin
      n_results++;
      got.mode = out_mode;
      got.mode_changed = out_mode_changed;
      got.step = out_step;
      got.value_changed = out_value_changed;
      got.mode_value = out_mode_value;
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with no sample pending", n_results);
      end else begin
        want = readout_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected mode %0d chg %0b step %0d vchg %0b value %0d,",
                      " got mode %0d chg %0b step %0d vchg %0b value %0d"},
                     n_results, want.mode, want.mode_changed, want.step,
                     want.value_changed, want.mode_value, got.mode, got.mode_changed,
                     got.step, got.value_changed, got.mode_value);
        end
      end
    end
    if (in_acc || out_acc || !(sample_q.size() != 0 || readout_q.size() != 0 || in_valid))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // driver
  sample_t nxt;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (snd_gap > 0) begin
        snd_gap--;
        in_valid <= 1'b0;
      end else if (!calm && sample_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        snd_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        nxt = sample_q.pop_front();
        in_time_ms <= nxt.time_ms;
        in_quad_a <= nxt.ab[0];
        in_quad_b <= nxt.ab[1];
        in_button_event <= nxt.ev;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_asks) begin
      holds_served = hold_asks;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rcv_gap = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_sample(input logic [TIME_BITS-1:0] t, input logic [1:0] ab,
                            input logic [EV_BITS-1:0] ev);
    sample_q.push_back('{t, ab, ev});
    clock_ms = t;
    pin_now = ab;
  endtask

  function automatic logic [1:0] next_ab(input logic [1:0] ab, input bit up);
    logic [1:0] n;
    case (ab)
      2'b00:   n = up ? 2'b10 : 2'b01;
      2'b10:   n = up ? 2'b11 : 2'b00;
      2'b11:   n = up ? 2'b01 : 2'b10;
      default: n = up ? 2'b00 : 2'b11;
    endcase
    return n;
  endfunction

  // mostly clean rotation with random timing, events and some pin noise
  task automatic push_walk(input int n);
    int                   k;
    logic [TIME_BITS-1:0] dt;
    logic [1:0]           ab;
    logic [EV_BITS-1:0]   ev;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70)      dt = $urandom_range(0, 15);
      else if (k < 88) dt = $urandom_range(0, 400);
      else if (k < 96) dt = $urandom_range(0, 30000);
      else             dt = $urandom;
      k = $urandom_range(0, 99);
      if (k < 3) turn_up = !turn_up;
      if (k < 70)      ab = next_ab(pin_now, turn_up);
      else if (k < 80) ab = pin_now;
      else if (k < 88) ab = next_ab(pin_now, !turn_up);
      else if (k < 94) ab = ~pin_now;
      else             ab = 2'($urandom_range(0, 3));
      ev = ($urandom_range(0, 99) < 8) ? EV_BITS'($urandom_range(1, 3)) : EV_NONE;
      add_sample(clock_ms + dt, ab, ev);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper bits carry junk to exercise masking
  task automatic configure(input logic [15:0] m0, input logic [15:0] m1,
                           input logic [15:0] m2, input logic [15:0] m3,
                           input logic [3:0] sat, input logic [15:0] idle,
                           input logic [31:0] mto);
    write_reg(CFG_MAX_NORMAL, ($urandom & 32'hFFFF_0000) | m0);
    write_reg(CFG_MAX_CLICKED, ($urandom & 32'hFFFF_0000) | m1);
    write_reg(CFG_MAX_DOUBLE, ($urandom & 32'hFFFF_0000) | m2);
    write_reg(CFG_MAX_HELD, ($urandom & 32'hFFFF_0000) | m3);
    write_reg(CFG_SAT_MASK, ($urandom & 32'hFFFF_FFF0) | sat);
    write_reg(CFG_IDLE_TO, ($urandom & 32'hFFFF_0000) | idle);
    write_reg(CFG_MODE_TO, mto);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || readout_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_limit();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 9)) : 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: rotations both ways with wrap, glitch, idle rounding, events
    add_sample(32'd0, 2'b00, EV_NONE);
    add_sample(32'd1, 2'b01, EV_NONE);
    add_sample(32'd2, 2'b11, EV_NONE);
    add_sample(32'd3, 2'b10, EV_NONE);
    add_sample(32'd4, 2'b00, EV_NONE);
    add_sample(32'd5, 2'b10, EV_NONE);
    add_sample(32'd6, 2'b11, EV_NONE);
    add_sample(32'd7, 2'b01, EV_NONE);
    add_sample(32'd8, 2'b00, EV_NONE);
    add_sample(32'd9, 2'b11, EV_NONE);
    add_sample(32'd10, 2'b01, EV_NONE);
    add_sample(32'd200, 2'b01, EV_NONE);
    add_sample(32'd201, 2'b11, EV_NONE);
    add_sample(32'd202, 2'b10, EV_NONE);
    add_sample(32'd400, 2'b10, EV_NONE);
    add_sample(32'd401, 2'b10, EV_CLICK);
    add_sample(32'd402, 2'b10, EV_CLICK);
    add_sample(32'd403, 2'b00, EV_DOUBLE);
    add_sample(32'd404, 2'b00, EV_HOLD);
    add_sample(32'd20000, 2'b00, EV_NONE);
    add_sample(32'd40000, 2'b00, EV_NONE);
    add_sample(32'hFFFF_FFFF, 2'b01, EV_HOLD);
    add_sample(32'd0, 2'b11, EV_NONE);
    add_sample(32'd1, 2'b10, EV_NONE);
    add_sample(32'd2, 2'b00, EV_NONE);
    drain();

    // small limits, fast timeouts, long output hold-off
    configure(16'd0, 16'd1, 16'd2, 16'hFFFF, 4'b0101, 16'd1, 32'd30);
    write_reg(CFG_UNUSED, $urandom);
    hold_asks++;
    push_walk(100);
    drain();

    // widest limits and timeouts, time crossing the wrap point
    configure(16'hFFFF, 16'd3, 16'd0, 16'd7, 4'b1010, 16'hFFFF, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FF00;
    push_walk(100);
    drain();

    // limits lowered under stored values, wrapping
    configure(16'd1, 16'd1, 16'd1, 16'd1, 4'h0, 16'd20, 32'd200);
    push_walk(100);
    drain();

    for (int p = 0; p < 4; p++) begin
      if (p == 3) calm = 1'b1;
      configure(pick_limit(), pick_limit(), pick_limit(), pick_limit(),
                4'($urandom_range(0, 15)), 16'($urandom_range(1, 300)),
                $urandom_range(1, 2000));
      clock_ms = $urandom;
      push_walk(85);
      drain();
    end

    $display("Checked %0d readouts from %0d samples over %0d register writes.",
             n_results, n_samples, n_cfg_writes);
    $display("Detent steps %0d, mode changes %0d, mismatches %0d.",
             n_steps, n_mode_changes, mismatches);
    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
